// ===== rtl/core/wot_pkg.sv =====
// Shared widths, constants, control states and the CORDIC arctangent table.
package wot_pkg;

   // Field widths
   localparam int CNT_W      = 32;
   localparam int HDG_W      = 27;
   localparam int CPC_W      = 24;
   localparam int POS_W      = 48;
   localparam int TRIG_FRAC  = 16;
   localparam int TRIG_W     = TRIG_FRAC + 2;
   localparam int DELTA_W    = CNT_W + 1;
   localparam int DIST_SHIFT = 16;
   localparam int DIST_W     = DELTA_W + CPC_W - DIST_SHIFT;
   localparam int INC_W      = DIST_W + TRIG_W - TRIG_FRAC + 1;

   localparam logic [CPC_W-1:0] CPC_RESET = CPC_W'(1022666);

   // Stream packing
   localparam int REQ_TDATA_W = 8 * ((3 * CNT_W + HDG_W + 7) / 8);
   localparam int REQ_TUSER_W = 1;
   localparam int RSP_TDATA_W = 8 * ((2 * POS_W + HDG_W + 7) / 8);

   // Heading to binary angle
   localparam int TURN           = 36000;
   localparam int ANG_W          = 32;
   localparam int REM_W          = $clog2(TURN);
   localparam int HDG_BIAS_SHIFT = 11;  // TURN << this covers the negative heading range
   localparam int HDG_BIAS       = TURN * (2 ** HDG_BIAS_SHIFT);
   localparam int DVD_W          = 2 * ((HDG_W + ANG_W + 1) / 2);
   localparam int DIV_STEPS      = DVD_W / 2;

   // CORDIC
   localparam int CORDIC_ITERS = 30;
   localparam int CORDIC_W     = 33;
   localparam int CORDIC_FRAC  = 30;
   localparam int ITER_W       = $clog2(CORDIC_ITERS);
   localparam logic [ANG_W-1:0] QTR_OFFSET = ANG_W'(32'h2000_0000);
   localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = CORDIC_W'(652032874);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_ROT,
      ST_MIX,
      ST_DONE
   } ctl_state_type;

   // atan(2^-i) in 2^32 units per turn
   function automatic logic [ANG_W-1:0] cordic_atan(input logic [ITER_W-1:0] idx);
      logic [ANG_W-1:0] v;
      unique case (idx)
         5'd0:  v = 32'h2000_0000;
         5'd1:  v = 32'h12E4_051E;
         5'd2:  v = 32'h09FB_385B;
         5'd3:  v = 32'h0511_11D4;
         5'd4:  v = 32'h028B_0D43;
         5'd5:  v = 32'h0145_D7E1;
         5'd6:  v = 32'h00A2_F61E;
         5'd7:  v = 32'h0051_7C55;
         5'd8:  v = 32'h0028_BE53;
         5'd9:  v = 32'h0014_5F2F;
         5'd10: v = 32'h000A_2F98;
         5'd11: v = 32'h0005_17CC;
         5'd12: v = 32'h0002_8BE6;
         5'd13: v = 32'h0001_45F3;
         5'd14: v = 32'h0000_A2FA;
         5'd15: v = 32'h0000_517D;
         5'd16: v = 32'h0000_28BE;
         5'd17: v = 32'h0000_145F;
         5'd18: v = 32'h0000_0A30;
         5'd19: v = 32'h0000_0518;
         5'd20: v = 32'h0000_028C;
         5'd21: v = 32'h0000_0146;
         5'd22: v = 32'h0000_00A3;
         5'd23: v = 32'h0000_0051;
         5'd24: v = 32'h0000_0029;
         5'd25: v = 32'h0000_0014;
         5'd26: v = 32'h0000_000A;
         5'd27: v = 32'h0000_0005;
         5'd28: v = 32'h0000_0003;
         5'd29: v = 32'h0000_0001;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/core/wot_scale.sv =====
// Serial-parallel multipliers turning both count deltas into distance, one factor bit per cycle.
module wot_scale (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [wot_pkg::DELTA_W-1:0]    delta_side,
   input  logic signed [wot_pkg::DELTA_W-1:0]    delta_fwd,
   input  logic        [wot_pkg::CPC_W-1:0]      cpc,
   output logic                                  busy,
   output logic signed [wot_pkg::DIST_W-1:0]     dist_x,
   output logic signed [wot_pkg::DIST_W-1:0]     dist_y
);

   localparam int ACC_W = wot_pkg::DELTA_W + 2;
   localparam int LOW_W = wot_pkg::CPC_W;
   localparam int CNT_W = $clog2(wot_pkg::CPC_W);
   localparam logic signed [ACC_W-1:0] RND_INIT = ACC_W'(2 ** (wot_pkg::DIST_SHIFT - 1));

   logic                       busy_ff, busy_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [LOW_W-1:0]           mult_ff, mult_in;
   logic signed [wot_pkg::DELTA_W-1:0] ds_ff, ds_in, df_ff, df_in;
   logic signed [ACC_W-1:0]    ax_ff, ax_in, ay_ff, ay_in;
   logic [LOW_W-1:0]           lx_ff, lx_in, ly_ff, ly_in;
   logic signed [ACC_W-1:0]    add_x, add_y, sum_x, sum_y;

   always_comb begin
      add_x = '0;
      add_y = '0;
      if (mult_ff[0]) begin
         add_x = ACC_W'(ds_ff);
         add_y = ACC_W'(df_ff);
      end
      sum_x = ax_ff + add_x;
      sum_y = ay_ff + add_y;

      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      mult_in = mult_ff;
      ds_in   = ds_ff;
      df_in   = df_ff;
      ax_in   = ax_ff;
      ay_in   = ay_ff;
      lx_in   = lx_ff;
      ly_in   = ly_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         mult_in = cpc;
         ds_in   = delta_side;
         df_in   = delta_fwd;
         ax_in   = RND_INIT;
         ay_in   = RND_INIT;
      end else if (busy_ff) begin
         // low product bits retire into lx/ly, high part stays in ax/ay
         ax_in   = sum_x >>> 1;
         ay_in   = sum_y >>> 1;
         lx_in   = {sum_x[0], lx_ff[LOW_W-1:1]};
         ly_in   = {sum_y[0], ly_ff[LOW_W-1:1]};
         mult_in = mult_ff >> 1;
         cnt_in  = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(wot_pkg::CPC_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff  <= cnt_in;
      mult_ff <= mult_in;
      ds_ff   <= ds_in;
      df_ff   <= df_in;
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      lx_ff   <= lx_in;
      ly_ff   <= ly_in;
   end

   assign busy   = busy_ff;
   assign dist_x = wot_pkg::DIST_W'({ax_ff, lx_ff[LOW_W-1:wot_pkg::DIST_SHIFT]});
   assign dist_y = wot_pkg::DIST_W'({ay_ff, ly_ff[LOW_W-1:wot_pkg::DIST_SHIFT]});

endmodule

// ===== rtl/core/wot_angle.sv =====
// Heading to 32-bit binary angle by radix-4 long division by a full turn.
module wot_angle (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [wot_pkg::HDG_W-1:0]    heading,
   output logic                                busy,
   output logic [wot_pkg::ANG_W-1:0]           angle
);

   localparam int CNT_W = $clog2(wot_pkg::DIV_STEPS);
   localparam int REM_W = wot_pkg::REM_W;
   localparam logic [REM_W:0] TURN_V = (REM_W + 1)'(wot_pkg::TURN);

   logic                         busy_ff, busy_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [wot_pkg::DVD_W-1:0]    dvd_ff, dvd_in;
   logic [REM_W-1:0]             rem_ff, rem_in;
   logic [wot_pkg::ANG_W-1:0]    quo_ff, quo_in;
   logic signed [wot_pkg::HDG_W:0] h_ext;
   logic [wot_pkg::HDG_W-1:0]    h_pos;
   logic [REM_W:0]               t1, t2;
   logic [REM_W-1:0]             r1, r2;
   logic                         ge1, ge2;

   always_comb begin
      // negative heading: add a whole number of turns to make it positive
      h_ext = (wot_pkg::HDG_W + 1)'(heading);
      if (heading < 0) begin
         h_ext = h_ext + (wot_pkg::HDG_W + 1)'(wot_pkg::HDG_BIAS);
      end
      h_pos = h_ext[wot_pkg::HDG_W-1:0];

      t1  = {rem_ff, dvd_ff[wot_pkg::DVD_W-1]};
      ge1 = (t1 >= TURN_V);
      r1  = ge1 ? REM_W'(t1 - TURN_V) : t1[REM_W-1:0];
      t2  = {r1, dvd_ff[wot_pkg::DVD_W-2]};
      ge2 = (t2 >= TURN_V);
      r2  = ge2 ? REM_W'(t2 - TURN_V) : t2[REM_W-1:0];

      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         // heading * 2^32 plus half a turn, so the quotient comes out rounded
         dvd_in  = wot_pkg::DVD_W'({h_pos, wot_pkg::ANG_W'(wot_pkg::TURN / 2)});
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = dvd_ff << 2;
         rem_in = r2;
         quo_in = {quo_ff[wot_pkg::ANG_W-3:0], ge1, ge2};  // whole turns fall off the top
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(wot_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy  = busy_ff;
   assign angle = quo_ff;

endmodule

// ===== rtl/core/wot_cordic.sv =====
// Iterative rotation-mode CORDIC giving rounded cosine and sine of a binary angle.
module wot_cordic (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [wot_pkg::ANG_W-1:0]           angle,
   output logic                                busy,
   output logic signed [wot_pkg::TRIG_W-1:0]   cos_q,
   output logic signed [wot_pkg::TRIG_W-1:0]   sin_q
);

   localparam int CW = wot_pkg::CORDIC_W;
   localparam int SH = wot_pkg::CORDIC_FRAC - wot_pkg::TRIG_FRAC;
   localparam logic signed [CW:0] RND = (CW + 1)'(2 ** (SH - 1));

   logic                              busy_ff, busy_in;
   logic [wot_pkg::ITER_W-1:0]        iter_ff, iter_in;
   logic signed [CW-1:0]              x_ff, x_in, y_ff, y_in;
   logic signed [wot_pkg::ANG_W-1:0]  z_ff, z_in;
   logic [1:0]                        q_ff, q_in;
   logic signed [CW-1:0]              xs, ys;
   logic signed [wot_pkg::ANG_W-1:0]  atan_v;
   logic [wot_pkg::ANG_W-1:0]         ang_off;
   logic signed [CW-1:0]              cq, sq;
   logic signed [CW:0]                cr, sr;

   always_comb begin
      xs      = x_ff >>> iter_ff;
      ys      = y_ff >>> iter_ff;
      atan_v  = $signed(wot_pkg::cordic_atan(iter_ff));
      ang_off = angle + wot_pkg::QTR_OFFSET;

      busy_in = busy_ff;
      iter_in = iter_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      q_in    = q_ff;
      if (start) begin
         // quadrant split leaves a residual in [-45, 45) degrees
         busy_in = 1'b1;
         iter_in = '0;
         q_in    = ang_off[wot_pkg::ANG_W-1 -: 2];
         z_in    = $signed(angle - {q_in, {(wot_pkg::ANG_W - 2){1'b0}}});
         x_in    = wot_pkg::CORDIC_X0;
         y_in    = '0;
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - atan_v;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + atan_v;
         end
         iter_in = iter_ff + wot_pkg::ITER_W'(1);
         if (iter_ff == wot_pkg::ITER_W'(wot_pkg::CORDIC_ITERS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      iter_ff <= iter_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      q_ff    <= q_in;
   end

   // undo the quadrant split, then round to the trig format
   always_comb begin
      case (q_ff)
         2'd1:    begin cq = -y_ff; sq = x_ff;  end
         2'd2:    begin cq = -x_ff; sq = -y_ff; end
         2'd3:    begin cq = y_ff;  sq = -x_ff; end
         default: begin cq = x_ff;  sq = y_ff;  end
      endcase
      cr = ((CW + 1)'(cq) + RND) >>> SH;
      sr = ((CW + 1)'(sq) + RND) >>> SH;
   end

   assign busy  = busy_ff;
   assign cos_q = cr[wot_pkg::TRIG_W-1:0];
   assign sin_q = sr[wot_pkg::TRIG_W-1:0];

endmodule

// ===== rtl/core/wot_rotate.sv =====
// Serial rotation of the distance pair: one cosine and one sine bit per cycle, rounded.
module wot_rotate (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [wot_pkg::DIST_W-1:0]   dist_x,
   input  logic signed [wot_pkg::DIST_W-1:0]   dist_y,
   input  logic signed [wot_pkg::TRIG_W-1:0]   cos_q,
   input  logic signed [wot_pkg::TRIG_W-1:0]   sin_q,
   output logic                                busy,
   output logic signed [wot_pkg::INC_W-1:0]    inc_x,
   output logic signed [wot_pkg::INC_W-1:0]    inc_y
);

   localparam int ACC_W = wot_pkg::DIST_W + 3;
   localparam int LOW_W = wot_pkg::TRIG_W;
   localparam int CNT_W = $clog2(wot_pkg::TRIG_W);
   localparam logic signed [ACC_W-1:0] RND_INIT = ACC_W'(2 ** (wot_pkg::TRIG_FRAC - 1));

   logic                       busy_ff, busy_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [LOW_W-1:0]           cs_ff, cs_in, sn_ff, sn_in;
   logic signed [wot_pkg::DIST_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [ACC_W-1:0]    ax_ff, ax_in, ay_ff, ay_in;
   logic [LOW_W-1:0]           lx_ff, lx_in, ly_ff, ly_in;
   logic signed [ACC_W-1:0]    c_dx, c_dy, s_dx, s_dy, px, py, sum_x, sum_y;
   logic                       last;

   always_comb begin
      c_dx = '0;
      c_dy = '0;
      s_dx = '0;
      s_dy = '0;
      if (cs_ff[0]) begin
         c_dx = ACC_W'(dx_ff);
         c_dy = ACC_W'(dy_ff);
      end
      if (sn_ff[0]) begin
         s_dx = ACC_W'(dx_ff);
         s_dy = ACC_W'(dy_ff);
      end
      px   = c_dx + s_dy;  // x: dx*cos + dy*sin
      py   = c_dy - s_dx;  // y: dy*cos - dx*sin
      last = (cnt_ff == CNT_W'(LOW_W - 1));
      // sign bit of the trig word weighs negative
      if (last) begin
         sum_x = ax_ff - px;
         sum_y = ay_ff - py;
      end else begin
         sum_x = ax_ff + px;
         sum_y = ay_ff + py;
      end

      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      cs_in   = cs_ff;
      sn_in   = sn_ff;
      dx_in   = dx_ff;
      dy_in   = dy_ff;
      ax_in   = ax_ff;
      ay_in   = ay_ff;
      lx_in   = lx_ff;
      ly_in   = ly_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         cs_in   = cos_q;
         sn_in   = sin_q;
         dx_in   = dist_x;
         dy_in   = dist_y;
         ax_in   = RND_INIT;
         ay_in   = RND_INIT;
      end else if (busy_ff) begin
         ax_in  = sum_x >>> 1;
         ay_in  = sum_y >>> 1;
         lx_in  = {sum_x[0], lx_ff[LOW_W-1:1]};
         ly_in  = {sum_y[0], ly_ff[LOW_W-1:1]};
         cs_in  = cs_ff >> 1;
         sn_in  = sn_ff >> 1;
         cnt_in = cnt_ff + CNT_W'(1);
         if (last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      cs_ff  <= cs_in;
      sn_ff  <= sn_in;
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      ax_ff  <= ax_in;
      ay_ff  <= ay_in;
      lx_ff  <= lx_in;
      ly_ff  <= ly_in;
   end

   assign busy  = busy_ff;
   assign inc_x = wot_pkg::INC_W'({ax_ff, lx_ff[LOW_W-1:wot_pkg::TRIG_FRAC]});
   assign inc_y = wot_pkg::INC_W'({ay_ff, ly_ff[LOW_W-1:wot_pkg::TRIG_FRAC]});

endmodule

// ===== rtl/core/wheel_odometry_tracker_core.sv =====
// Top level of the odometry tracker: stream ports, tick state, control and saturating accumulators.
//
// Dead reckoning from three tracking encoders and an IMU heading. Each req item carries the
// cumulative side and two forward encoder counts plus a heading in centidegrees with a valid
// flag; each item yields exactly one rsp item with the saturating x/y position in 1/256 cm and
// the heading applied. An invalid heading keeps the last good one. One item is worked at a
// time; the next is taken only once control is back in idle. Each item passes a chain of
// serial units: radix-4 division turning the heading into a binary angle, with the
// count-to-distance multiply alongside it, then 30 CORDIC iterations, then bit-serial
// rotation, and the result is loaded in the done state. The rsp item sits in an output
// register, so a new req item is taken while the previous result waits; the next result
// then waits until that one is taken. cm_per_count is written through csr_ and must only
// change while no item is in flight; it resets to 1022666 (Q0.24).
module wheel_odometry_tracker_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // req item
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [31:0] side_count, [63:32] fwd_count_a, [95:64] fwd_count_b, [122:96] heading_centideg
   input  logic [wot_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // [0] heading_valid
   input  logic [wot_pkg::REQ_TUSER_W-1:0]      req_tuser,
   // rsp item
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [47:0] pos_x, [95:48] pos_y, [122:96] heading_used
   output logic [wot_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // cm_per_count write
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [wot_pkg::CPC_W-1:0]            csr_data
);

   localparam int CNT_W   = wot_pkg::CNT_W;
   localparam int DELTA_W = wot_pkg::DELTA_W;
   localparam int HDG_W   = wot_pkg::HDG_W;
   localparam int POS_W   = wot_pkg::POS_W;
   localparam int INC_W   = wot_pkg::INC_W;
   localparam int SUM_W   = ((POS_W > INC_W) ? POS_W : INC_W) + 1;
   localparam logic signed [SUM_W-1:0] POS_HI = SUM_W'({1'b0, {(POS_W - 1){1'b1}}});
   localparam logic signed [SUM_W-1:0] POS_LO = -POS_HI - SUM_W'(1);

   wot_pkg::ctl_state_type state_ff, state_in;

   logic [wot_pkg::CPC_W-1:0]   cpc_ff, cpc_in;
   logic signed [CNT_W-1:0]     prev_side_ff, prev_side_in;
   logic signed [CNT_W-1:0]     prev_avg_ff, prev_avg_in;
   logic signed [HDG_W-1:0]     good_hdg_ff, good_hdg_in;
   logic signed [POS_W-1:0]     acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic signed [HDG_W-1:0]     hdg_out_ff, hdg_out_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   // unpacked req fields
   logic signed [CNT_W-1:0]     side_count, fwd_count_a, fwd_count_b;
   logic signed [HDG_W-1:0]     heading_centideg;
   logic                        heading_valid;

   logic                        req_fire, rsp_fire, out_free;
   logic signed [DELTA_W-1:0]   fwd_sum, fwd_adj, delta_side, delta_fwd;
   logic signed [CNT_W-1:0]     fwd_avg;
   logic signed [HDG_W-1:0]     hdg_sel;
   logic signed [SUM_W-1:0]     sum_x, sum_y;

   // unit control
   logic                        tick_start, cordic_start, mix_start, out_load;
   logic                        scale_busy, angle_busy, cordic_busy, mix_busy;
   logic signed [wot_pkg::DIST_W-1:0] dist_x, dist_y;
   logic [wot_pkg::ANG_W-1:0]   angle;
   logic signed [wot_pkg::TRIG_W-1:0] cos_q, sin_q;
   logic signed [INC_W-1:0]     inc_x, inc_y;

   assign side_count       = $signed(req_tdata[CNT_W-1:0]);
   assign fwd_count_a      = $signed(req_tdata[2*CNT_W-1:CNT_W]);
   assign fwd_count_b      = $signed(req_tdata[3*CNT_W-1:2*CNT_W]);
   assign heading_centideg = $signed(req_tdata[3*CNT_W+HDG_W-1:3*CNT_W]);
   assign heading_valid    = req_tuser[0];

   assign req_tready = (state_ff == wot_pkg::ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_fire   = rsp_valid_ff & rsp_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign csr_ready  = 1'b1;

   // forward average truncates toward zero: bump negative sums by one before the shift
   always_comb begin
      fwd_sum    = DELTA_W'(fwd_count_a) + DELTA_W'(fwd_count_b);
      fwd_adj    = fwd_sum + $signed({{(DELTA_W - 1){1'b0}}, fwd_sum[DELTA_W-1]});
      fwd_avg    = CNT_W'(fwd_adj >>> 1);
      delta_side = DELTA_W'(side_count) - DELTA_W'(prev_side_ff);
      delta_fwd  = DELTA_W'(fwd_avg) - DELTA_W'(prev_avg_ff);
      hdg_sel    = heading_valid ? heading_centideg : good_hdg_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wot_pkg::ST_IDLE: if (req_fire) state_in = wot_pkg::ST_CONV;
         wot_pkg::ST_CONV: if (!angle_busy && !scale_busy) state_in = wot_pkg::ST_ROT;
         wot_pkg::ST_ROT:  if (!cordic_busy) state_in = wot_pkg::ST_MIX;
         wot_pkg::ST_MIX:  if (!mix_busy) state_in = wot_pkg::ST_DONE;
         wot_pkg::ST_DONE: if (out_free) state_in = wot_pkg::ST_IDLE;
         default:          state_in = wot_pkg::ST_IDLE;
      endcase
   end

   // state machine outputs
   always_comb begin
      tick_start   = 1'b0;
      cordic_start = 1'b0;
      mix_start    = 1'b0;
      out_load     = 1'b0;
      unique case (state_ff)
         wot_pkg::ST_IDLE: tick_start   = req_fire;
         wot_pkg::ST_CONV: cordic_start = ~angle_busy & ~scale_busy;
         wot_pkg::ST_ROT:  mix_start    = ~cordic_busy;
         wot_pkg::ST_MIX:  ;
         wot_pkg::ST_DONE: out_load     = out_free;
         default:          ;
      endcase
   end

   // cm_per_count write, tick state, saturating accumulate and output register
   always_comb begin
      cpc_in       = cpc_ff;
      prev_side_in = prev_side_ff;
      prev_avg_in  = prev_avg_ff;
      good_hdg_in  = good_hdg_ff;
      acc_x_in     = acc_x_ff;
      acc_y_in     = acc_y_ff;
      hdg_out_in   = hdg_out_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_fire;

      sum_x = SUM_W'(acc_x_ff) + SUM_W'(inc_x);
      sum_y = SUM_W'(acc_y_ff) + SUM_W'(inc_y);

      if (csr_valid) begin
         cpc_in = csr_data;
      end
      if (tick_start) begin
         prev_side_in = side_count;
         prev_avg_in  = fwd_avg;
         good_hdg_in  = hdg_sel;
      end
      if (out_load) begin
         // the accumulators double as the position fields of the rsp item
         if (sum_x > POS_HI) begin
            acc_x_in = POS_HI[POS_W-1:0];
         end else if (sum_x < POS_LO) begin
            acc_x_in = POS_LO[POS_W-1:0];
         end else begin
            acc_x_in = sum_x[POS_W-1:0];
         end
         if (sum_y > POS_HI) begin
            acc_y_in = POS_HI[POS_W-1:0];
         end else if (sum_y < POS_LO) begin
            acc_y_in = POS_LO[POS_W-1:0];
         end else begin
            acc_y_in = sum_y[POS_W-1:0];
         end
         // good_hdg changes with the next item while this result waits, so latch it separately
         hdg_out_in   = good_hdg_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wot_pkg::ST_IDLE;
         cpc_ff       <= wot_pkg::CPC_RESET;
         prev_side_ff <= '0;
         prev_avg_ff  <= '0;
         good_hdg_ff  <= '0;
         acc_x_ff     <= '0;
         acc_y_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cpc_ff       <= cpc_in;
         prev_side_ff <= prev_side_in;
         prev_avg_ff  <= prev_avg_in;
         good_hdg_ff  <= good_hdg_in;
         acc_x_ff     <= acc_x_in;
         acc_y_ff     <= acc_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hdg_out_ff <= hdg_out_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = wot_pkg::RSP_TDATA_W'({hdg_out_ff, acc_y_ff, acc_x_ff});

   wot_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .start      (tick_start),
      .delta_side (delta_side),
      .delta_fwd  (delta_fwd),
      .cpc        (cpc_ff),
      .busy       (scale_busy),
      .dist_x     (dist_x),
      .dist_y     (dist_y)
   );

   wot_angle u_angle (
      .clock   (clock),
      .reset   (reset),
      .start   (tick_start),
      .heading (hdg_sel),
      .busy    (angle_busy),
      .angle   (angle)
   );

   wot_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .angle (angle),
      .busy  (cordic_busy),
      .cos_q (cos_q),
      .sin_q (sin_q)
   );

   wot_rotate u_rotate (
      .clock  (clock),
      .reset  (reset),
      .start  (mix_start),
      .dist_x (dist_x),
      .dist_y (dist_y),
      .cos_q  (cos_q),
      .sin_q  (sin_q),
      .busy   (mix_busy),
      .inc_x  (inc_x),
      .inc_y  (inc_y)
   );

endmodule

// ===== rtl/core/wot_port_checker.sv =====
// Port-level checks for the odometry tracker, bound to the top level.
module wot_port_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [wot_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   // one item at a time: no second accept right behind the first
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("req_tready high right after an accepted item");

   // a result never appears right after an accept
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !$rose(rsp_tvalid))
      else $error("rsp item appeared one cycle after accept");

   // reset leaves no result pending
   a_reset_clears: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled rsp item dropped or changed");

endmodule

bind wheel_odometry_tracker_core wot_port_checker u_port_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
